// ===== rtl/core/iq_byte_magnitude_macros.svh =====
// ============================================================================
// iq_byte_magnitude assertion macros
// Shared concurrent assertion forms for the I/Q magnitude checker.
// ============================================================================
`ifndef IQ_BYTE_MAGNITUDE_MACROS_SVH
`define IQ_BYTE_MAGNITUDE_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define IQBM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("iq_byte_magnitude: same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted.
`define IQBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("iq_byte_magnitude: next-cycle check failed");

`endif

// ===== rtl/core/iqbm_pkg.sv =====
// ============================================================================
// iqbm_pkg
// Widths and fixed-point constants of the I/Q byte magnitude pipeline.
// ============================================================================
package iqbm_pkg;

    // Field widths of the stream items.
    localparam int SAMPLE_W = 8;
    localparam int MAG_W    = 16;

    // Components are held scaled by five: 5*x - 637 covers -637..638.
    localparam int COMP_W = 11;
    localparam logic [COMP_W-1:0] COMP_OFFSET = 11'd637;

    // One square is at most 638^2, the sum of two fits 20 bits.
    localparam int SQ_W  = 19;
    localparam int SUM_W = 20;

    // 262144 / 25 = 10485 remainder 19, so the scaled value is
    // 10485*S + floor(19*S/25).
    localparam int WHOLE_W = 33;
    localparam logic [13:0] DIV_WHOLE = 14'd10485;
    localparam logic [4:0]  DIV_FRAC  = 5'd19;

    // Exact reciprocal of 25 for numerators below 2^24.
    localparam int FRAC_W      = 24;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 29;
    localparam logic [RECIP_W-1:0] RECIP_25 = 25'd21474837;
    localparam int QUOT_W = 20;

    // Square root: one result bit per stage over a 32-bit radicand.
    localparam int ROOT_W = MAG_W;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 1;

    // Stage numbering: six arithmetic stages, then the root stages.
    localparam int SQRT_BASE  = 6;
    localparam int PIPE_DEPTH = SQRT_BASE + ROOT_W;

    // Smallest magnitude any sample can give (both components at -2/5).
    localparam logic [MAG_W-1:0] MAG_FLOOR = 16'd289;

endpackage

// ===== rtl/core/iq_byte_magnitude.sv =====
// ============================================================================
// iq_byte_magnitude
// Magnitude of an offset-binary 8-bit I/Q pair, 512 per unit, saturated.
// ============================================================================
// The block takes one I/Q sample pair per clock while s_axis_tready is high
// and returns its magnitude: six stages form the scaled sum of squares and
// the exact division by 25; sixteen stages each settle one square root bit.
// A result waiting at the output does not stop intake: empty stages ahead of
// it are filled, and only a fully occupied pipeline pushes back on
// s_axis_tready. The tlast flag travels alongside its sample unchanged.
module iq_byte_magnitude
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] i_sample, [15:8] q_sample
    input  logic        s_axis_tlast,   // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] magnitude
    output logic        m_axis_tlast    // last_out
);

    localparam int DEPTH  = iqbm_pkg::PIPE_DEPTH;
    localparam int BASE   = iqbm_pkg::SQRT_BASE;
    localparam int ROOT_W = iqbm_pkg::ROOT_W;
    localparam int REM_W  = iqbm_pkg::REM_W;
    localparam int RAD_W  = iqbm_pkg::RAD_W;
    localparam int COMP_W = iqbm_pkg::COMP_W;

    // Pipeline occupancy and per-stage load enables.
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] stage_ready;
    logic [DEPTH-1:0] stage_load;
    logic [DEPTH-1:0] last_reg;

    // Valid and last flags offered to each stage by the one before it.
    logic [DEPTH-1:0] valid_feed;
    logic [DEPTH-1:0] last_feed;

    // Arithmetic stage payloads.
    logic signed [COMP_W-1:0]        ci_reg, cq_reg;
    logic [iqbm_pkg::SQ_W-1:0]       sqi_reg, sqq_reg;
    logic [iqbm_pkg::SUM_W-1:0]      sum_reg;
    logic [iqbm_pkg::WHOLE_W-1:0]    whole_reg, whole2_reg;
    logic [iqbm_pkg::FRAC_W-1:0]     frac_reg;
    logic [iqbm_pkg::QUOT_W-1:0]     quot_reg;
    logic [iqbm_pkg::WHOLE_W-1:0]    rad_reg;

    // Root stage payloads; the last stage keeps only the root.
    logic [REM_W-1:0]  rem_reg  [ROOT_W-1];
    logic [RAD_W-1:0]  xs_reg   [ROOT_W-1];
    logic              sat_reg  [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    assign valid_feed = {valid_reg[DEPTH-2:0], s_axis_tvalid};
    assign last_feed  = {last_reg[DEPTH-2:0], s_axis_tlast};

    // A stage can take new data when the output is ready or when it or any stage after it is empty.
    for (genvar k = 0; k < DEPTH; k++) begin : g_ready
        assign stage_ready[k] = m_axis_tready || !(&valid_reg[DEPTH-1:k]);
        if (k == 0) begin : g_head
            assign stage_load[k] = stage_ready[k] && s_axis_tvalid;
        end else begin : g_body
            assign stage_load[k] = stage_ready[k] && valid_reg[k-1];
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_feed[k];
                end
            end
        end
    end

    // The last flag follows its sample through every stage.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            if (stage_load[k])
            begin
                last_reg[k] <= last_feed[k];
            end
        end
    end

    // Stage 0: components scaled by five, offset removed.
    logic [COMP_W-1:0] ci_five, cq_five;
    assign ci_five = {1'b0, s_axis_tdata[7:0], 2'b00} + {3'b000, s_axis_tdata[7:0]};
    assign cq_five = {1'b0, s_axis_tdata[15:8], 2'b00} + {3'b000, s_axis_tdata[15:8]};

    always_ff @(posedge clk)
    begin
        if (stage_load[0])
        begin
            ci_reg <= $signed(ci_five - iqbm_pkg::COMP_OFFSET);
            cq_reg <= $signed(cq_five - iqbm_pkg::COMP_OFFSET);
        end
    end

    // Stage 1: squares of the components.
    logic signed [2*COMP_W-1:0] prod_i, prod_q;
    assign prod_i = ci_reg * ci_reg;
    assign prod_q = cq_reg * cq_reg;

    always_ff @(posedge clk)
    begin
        if (stage_load[1])
        begin
            sqi_reg <= prod_i[iqbm_pkg::SQ_W-1:0];
            sqq_reg <= prod_q[iqbm_pkg::SQ_W-1:0];
        end
    end

    // Stage 2: sum of squares.
    always_ff @(posedge clk)
    begin
        if (stage_load[2])
        begin
            sum_reg <= {1'b0, sqi_reg} + {1'b0, sqq_reg};
        end
    end

    // Stage 3: whole part of the scaling and the numerator of its fraction.
    logic [33:0] whole_prod;
    logic [24:0] frac_prod;
    assign whole_prod = {14'd0, sum_reg} * {20'd0, iqbm_pkg::DIV_WHOLE};
    assign frac_prod  = {5'd0, sum_reg} * {20'd0, iqbm_pkg::DIV_FRAC};

    always_ff @(posedge clk)
    begin
        if (stage_load[3])
        begin
            whole_reg <= whole_prod[iqbm_pkg::WHOLE_W-1:0];
            frac_reg  <= frac_prod[iqbm_pkg::FRAC_W-1:0];
        end
    end

    // Stage 4: divide the fraction numerator by 25 through its reciprocal.
    logic [iqbm_pkg::FRAC_W+iqbm_pkg::RECIP_W-1:0] recip_prod;
    assign recip_prod = {{iqbm_pkg::RECIP_W{1'b0}}, frac_reg}
                      * {{iqbm_pkg::FRAC_W{1'b0}}, iqbm_pkg::RECIP_25};

    always_ff @(posedge clk)
    begin
        if (stage_load[4])
        begin
            whole2_reg <= whole_reg;
            quot_reg   <= recip_prod[iqbm_pkg::RECIP_SHIFT +: iqbm_pkg::QUOT_W];
        end
    end

    // Stage 5: radicand for the square root.
    always_ff @(posedge clk)
    begin
        if (stage_load[5])
        begin
            rad_reg <= whole2_reg
                     + {{(iqbm_pkg::WHOLE_W-iqbm_pkg::QUOT_W){1'b0}}, quot_reg};
        end
    end

    // Root stages: each brings in two radicand bits and settles one root bit.
    // A radicand of 2^32 or more saturates the result.
    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [RAD_W-1:0]  xs_prev;
        logic              sat_prev;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              take;
        logic [ROOT_W-1:0] root_new;

        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign xs_prev   = rad_reg[RAD_W-1:0];
            assign sat_prev  = rad_reg[RAD_W];
        end else begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign xs_prev   = xs_reg[k-1];
            assign sat_prev  = sat_reg[k-1];
        end

        assign rem_sh   = {rem_prev, xs_prev[RAD_W-1 -: 2]};
        assign trial    = {1'b0, root_prev, 2'b01};
        assign take     = (rem_sh >= trial);
        assign root_new = {root_prev[ROOT_W-2:0], take};

        if (k == ROOT_W - 1) begin : g_out
            always_ff @(posedge clk)
            begin
                if (stage_load[BASE+k])
                begin
                    root_reg[k] <= sat_prev ? {ROOT_W{1'b1}} : root_new;
                end
            end
        end else begin : g_mid
            // The remainder after a taken trial always fits its register.
            logic [REM_W-1:0] diff;
            assign diff = rem_sh[REM_W-1:0] - trial[REM_W-1:0];

            always_ff @(posedge clk)
            begin
                if (stage_load[BASE+k])
                begin
                    root_reg[k] <= root_new;
                    rem_reg[k]  <= take ? diff : rem_sh[REM_W-1:0];
                    xs_reg[k]   <= {xs_prev[RAD_W-3:0], 2'b00};
                    sat_reg[k]  <= sat_prev;
                end
            end
        end
    end

    // Stream ports.
    assign s_axis_tready = stage_ready[0];
    assign m_axis_tvalid = valid_reg[DEPTH-1];
    assign m_axis_tdata  = root_reg[ROOT_W-1];
    assign m_axis_tlast  = last_reg[DEPTH-1];

endmodule

// ===== rtl/core/iqbm_checker.sv =====
// ============================================================================
// iqbm_checker
// Port-level checks of the I/Q byte magnitude block, bound to its top level.
// ============================================================================
`include "iq_byte_magnitude_macros.svh"

module iqbm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result stays offered.
    `IQBM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // A stalled result keeps its payload.
    `IQBM_ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // With the output free, the pipeline always has room for a new transfer.
    `IQBM_ASSERT_NOW(a_in_room, clk, rst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready)

    // No sample pair lies closer to the centre than both components at two fifths.
    `IQBM_ASSERT_NOW(a_mag_floor, clk, rst_n, m_axis_tvalid, m_axis_tdata >= iqbm_pkg::MAG_FLOOR)

endmodule

bind iq_byte_magnitude iqbm_checker u_iqbm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
